### src/ptld_pkg.sv
package ptld_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIST_W  = 34;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } pt_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              degenerate;
  } pt_out_t;

endpackage

### src/point_to_line_distance_3d.sv
// Throughput: one point per cycle unless out_ready_i is low with a result held;
// every stage is registered and advances together.
// Stages: difference, six cross-product terms, magnitude, split squares, sum, one
// quotient bit per stage of restoring division, one root bit per stage of square root.
// Reset: asynchronous, active low; clears all valid bits and loads origin 0 and
// direction +x (1.0); the |d|^2 register follows the direction via dsq_q and dzero_q.
module point_to_line_distance_3d
  import ptld_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [COORD_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pt_in_t             in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pt_out_t            out_data_o
);

  localparam int unsigned CW  = COORD_W;
  localparam int unsigned VW  = CW + 1;
  localparam int unsigned PRW = VW + CW;
  localparam int unsigned CRW = PRW + 1;
  localparam int unsigned MW  = 2 * CW + 1;
  localparam int unsigned H   = (MW + 1) / 2;
  localparam int unsigned HW  = MW - H;
  localparam int unsigned SQW = 2 * MW;
  localparam int unsigned NW  = SQW + 2;
  localparam int unsigned DW  = 2 * CW;
  localparam int unsigned QW  = 2 * CW + 2;
  localparam int unsigned RW  = CW + 1;
  localparam int unsigned RMW = RW + 2;
  localparam int unsigned SW  = (RW > DIST_W) ? RW : DIST_W;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5
  } cfg_idx_e;

  logic signed [CW-1:0] org_q [3];
  logic signed [CW-1:0] dir_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= CW'(65536);
      dir_q[1] <= '0;
      dir_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ORIGIN_X: org_q[0] <= cfg_wdata_i;
        CFG_ORIGIN_Y: org_q[1] <= cfg_wdata_i;
        CFG_ORIGIN_Z: org_q[2] <= cfg_wdata_i;
        CFG_DIR_X:    dir_q[0] <= cfg_wdata_i;
        CFG_DIR_Y:    dir_q[1] <= cfg_wdata_i;
        CFG_DIR_Z:    dir_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic dir_zero;
  assign dir_zero = (dir_q[0] == '0) && (dir_q[1] == '0) && (dir_q[2] == '0);

  // |d|^2, or 1 for a zero direction
  logic [DW-1:0] dsq_q [3];
  logic          dzero_q;
  logic [DW-1:0] den_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dsq_q[i] <= DW'(dir_q[i]) * DW'(dir_q[i]);
    end
    dzero_q <= dir_zero;
    den_q   <= dzero_q ? DW'(1) : (dsq_q[0] + dsq_q[1] + dsq_q[2]);
  end

  // pipeline advance and input skid
  logic   en;
  logic   out_valid_q;
  pt_out_t out_data_q;
  logic   skid_valid_q;
  pt_in_t skid_data_q;
  logic   in_fire;
  logic   s0_valid;
  pt_in_t s0_data;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s0_valid   = skid_valid_q || in_fire;
  assign s0_data    = skid_valid_q ? skid_data_q : in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (en) begin
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_fire) begin
      skid_data_q <= in_data_i;
    end
  end

  // S1: v = p - p0
  logic                 s1_valid_q, s1_degen_q;
  logic signed [VW-1:0] s1_v_q [3];
  // S2: cross products
  logic                  s2_valid_q, s2_degen_q;
  logic signed [VW-1:0]  s2_v_q [3];
  logic signed [PRW-1:0] s2_p_q [6];
  // S3: magnitudes
  logic          s3_valid_q, s3_degen_q;
  logic [MW-1:0] s3_m_q [3];
  // S4: partial squares
  logic            s4_valid_q, s4_degen_q;
  logic [2*H-1:0]  s4_ll_q [3];
  logic [H+HW-1:0] s4_lh_q [3];
  logic [2*HW-1:0] s4_hh_q [3];
  // S5: squares
  logic           s5_valid_q, s5_degen_q;
  logic [SQW-1:0] s5_sq_q [3];

  logic signed [CRW-1:0] s3_c [3];
  logic [NW-1:0]         s5_num;

  always_comb begin
    s3_c[0] = CRW'(s2_p_q[0]) - CRW'(s2_p_q[1]);
    s3_c[1] = CRW'(s2_p_q[2]) - CRW'(s2_p_q[3]);
    s3_c[2] = CRW'(s2_p_q[4]) - CRW'(s2_p_q[5]);
    if (s2_degen_q) begin
      for (int i = 0; i < 3; i++) begin
        s3_c[i] = CRW'(s2_v_q[i]);
      end
    end
  end

  assign s5_num = NW'(s5_sq_q[0]) + NW'(s5_sq_q[1]) + NW'(s5_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s0_valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_degen_q <= dir_zero;
      s1_v_q[0]  <= VW'(s0_data.point_x) - VW'(org_q[0]);
      s1_v_q[1]  <= VW'(s0_data.point_y) - VW'(org_q[1]);
      s1_v_q[2]  <= VW'(s0_data.point_z) - VW'(org_q[2]);

      s2_degen_q <= s1_degen_q;
      s2_v_q     <= s1_v_q;
      s2_p_q[0]  <= PRW'(s1_v_q[1]) * PRW'(dir_q[2]);
      s2_p_q[1]  <= PRW'(s1_v_q[2]) * PRW'(dir_q[1]);
      s2_p_q[2]  <= PRW'(s1_v_q[2]) * PRW'(dir_q[0]);
      s2_p_q[3]  <= PRW'(s1_v_q[0]) * PRW'(dir_q[2]);
      s2_p_q[4]  <= PRW'(s1_v_q[0]) * PRW'(dir_q[1]);
      s2_p_q[5]  <= PRW'(s1_v_q[1]) * PRW'(dir_q[0]);

      s3_degen_q <= s2_degen_q;
      s4_degen_q <= s3_degen_q;
      s5_degen_q <= s4_degen_q;
      for (int i = 0; i < 3; i++) begin
        s3_m_q[i]  <= s3_c[i][CRW-1] ? MW'(-s3_c[i]) : MW'(s3_c[i]);
        s4_ll_q[i] <= (2*H)'(s3_m_q[i][H-1:0]) * (2*H)'(s3_m_q[i][H-1:0]);
        s4_lh_q[i] <= (H+HW)'(s3_m_q[i][H-1:0]) * (H+HW)'(s3_m_q[i][MW-1:H]);
        s4_hh_q[i] <= (2*HW)'(s3_m_q[i][MW-1:H]) * (2*HW)'(s3_m_q[i][MW-1:H]);
        s5_sq_q[i] <= (SQW'(s4_hh_q[i]) << (2*H)) + (SQW'(s4_lh_q[i]) << (H+1))
                      + SQW'(s4_ll_q[i]);
      end
    end
  end

  // division: one quotient bit per stage
  logic          dv_valid_q [QW+1];
  logic          dv_degen_q [QW+1];
  logic [DW-1:0] dv_rem_q   [QW+1];
  logic [QW-1:0] dv_low_q   [QW+1];
  logic [QW-1:0] dv_quo_q   [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q[0] <= 1'b0;
    end else if (en) begin
      dv_valid_q[0] <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_degen_q[0] <= s5_degen_q;
      dv_rem_q[0]   <= s5_num[QW+DW-1:QW];
      dv_low_q[0]   <= s5_num[QW-1:0];
      dv_quo_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0] trial;
    logic        ge;
    assign trial = {dv_rem_q[k], dv_low_q[k][QW-1]};
    assign ge    = trial >= {1'b0, den_q};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_valid_q[k+1] <= dv_valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_degen_q[k+1] <= dv_degen_q[k];
        dv_rem_q[k+1]   <= ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
        dv_low_q[k+1]   <= dv_low_q[k] << 1;
        dv_quo_q[k+1]   <= {dv_quo_q[k][QW-2:0], ge};
      end
    end
  end

  // square root: one root bit per stage
  logic           sr_valid_q [RW+1];
  logic           sr_degen_q [RW+1];
  logic [RMW-1:0] sr_rem_q   [RW+1];
  logic [RW-1:0]  sr_root_q  [RW+1];
  logic [QW-1:0]  sr_rad_q   [RW+1];

  assign sr_valid_q[0] = dv_valid_q[QW];
  assign sr_degen_q[0] = dv_degen_q[QW];
  assign sr_rem_q[0]   = '0;
  assign sr_root_q[0]  = '0;
  assign sr_rad_q[0]   = dv_quo_q[QW];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [RMW-1:0] nrem;
    logic [RMW-1:0] trial;
    logic           ge;
    assign nrem  = {sr_rem_q[j][RMW-3:0], sr_rad_q[j][QW-1:QW-2]};
    assign trial = {sr_root_q[j], 2'b01};
    assign ge    = nrem >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_valid_q[j+1] <= 1'b0;
      end else if (en) begin
        sr_valid_q[j+1] <= sr_valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_degen_q[j+1] <= sr_degen_q[j];
        sr_rem_q[j+1]   <= ge ? (nrem - trial) : nrem;
        sr_root_q[j+1]  <= {sr_root_q[j][RW-2:0], ge};
        sr_rad_q[j+1]   <= sr_rad_q[j] << 2;
      end
    end
  end

  // output register, saturate
  logic [SW-1:0] root_ext;
  pt_out_t       out_d;

  assign root_ext = SW'(sr_root_q[RW]);

  always_comb begin
    out_d.degenerate = sr_degen_q[RW];
    out_d.distance   = (root_ext > SW'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sr_valid_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && en |=> !skid_valid_q)
    else $error("skid entry not drained on advance");

  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && in_fire |=> skid_valid_q)
    else $error("transfer during stall not captured");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s1_valid_q) && $stable(dv_valid_q[0]))
    else $error("pipeline moved while stalled");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid_q[0] |-> den_q != '0)
    else $error("zero divisor in division pipe");

endmodule

### sim/tb_point_to_line_distance_3d.sv
module tb_point_to_line_distance_3d;
  import ptld_pkg::*;

  localparam logic signed [COORD_W-1:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] CMIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] ONE  = 32'sh0001_0000;

  typedef enum logic [2:0] {
    REG_ORG_X = 3'd0, REG_ORG_Y = 3'd1, REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3, REG_DIR_Y = 3'd4, REG_DIR_Z = 3'd5,
    REG_NONE_A = 3'd6, REG_NONE_B = 3'd7
  } reg_idx_e;

  typedef enum int {LINE_RESET, LINE_ZERO_DIR, LINE_FAR} line_set_e;

  typedef struct {
    line_set_e line;
    pt_in_t    p;
    bit        typed;
    pt_out_t   e;
  } row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    cfg_we_i = 1'b0;
  logic [2:0] cfg_addr_i = '0;
  logic [COORD_W-1:0] cfg_wdata_i = '0;
  logic    in_valid_i = 1'b0;
  logic    in_ready_o;
  pt_in_t  in_data_i = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  pt_out_t out_data_o;

  logic signed [COORD_W-1:0] line_org [3];
  logic signed [COORD_W-1:0] line_dir [3];
  pt_out_t dist_q [$];
  int      errors = 0;
  int      tx_idle = 0;
  int      rx_idle = 0;

  point_to_line_distance_3d dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic pt_out_t line_distance(pt_in_t p);
    logic signed [191:0] vx, vy, vz, dx, dy, dz, cx, cy, cz, num, den, c;
    pt_out_t r;
    vx = p.point_x; vx = vx - line_org[0];
    vy = p.point_y; vy = vy - line_org[1];
    vz = p.point_z; vz = vz - line_org[2];
    dx = line_dir[0]; dy = line_dir[1]; dz = line_dir[2];
    r.degenerate = (dx == 0) && (dy == 0) && (dz == 0);
    if (r.degenerate) begin
      num = vx * vx + vy * vy + vz * vz;
      den = 1;
    end else begin
      cx = vy * dz - vz * dy;
      cy = vz * dx - vx * dz;
      cz = vx * dy - vy * dx;
      num = cx * cx + cy * cy + cz * cz;
      den = dx * dx + dy * dy + dz * dz;
    end
    r.distance = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      c = r.distance | (34'd1 << b);
      if (c * c * den <= num) r.distance = c[DIST_W-1:0];
    end
    return r;
  endfunction

  function automatic pt_in_t pt(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                logic signed [COORD_W-1:0] z);
    pt_in_t p;
    p.point_x = x; p.point_y = y; p.point_z = z;
    return p;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return CMAX;
      1: return CMIN;
      2: return 0;
      3, 4: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      default: return $urandom;
    endcase
  endfunction

  task automatic settle();
    in_valid_i = 1'b0;
    wait (dist_q.size() == 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [COORD_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = val;
    if (idx <= REG_ORG_Z) line_org[idx] = val;
    else if (idx <= REG_DIR_Z) line_dir[idx - REG_DIR_X] = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_line(logic signed [COORD_W-1:0] o [3], logic signed [COORD_W-1:0] d [3]);
    settle();
    write_reg(REG_ORG_X, o[0]); write_reg(REG_ORG_Y, o[1]); write_reg(REG_ORG_Z, o[2]);
    write_reg(REG_DIR_X, d[0]); write_reg(REG_DIR_Y, d[1]); write_reg(REG_DIR_Z, d[2]);
    write_reg(REG_NONE_A, $urandom);
    write_reg(REG_NONE_B, $urandom);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic send(pt_in_t p, bit typed, pt_out_t e);
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = p;
    do @(posedge clk_i); while (!in_ready_o);
    dist_q.push_back(typed ? e : line_distance(p));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= rx_idle);

  always @(posedge clk_i) begin
    pt_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dist_q.size() == 0) begin
        $display("%0t: unexpected result distance=%0d degenerate=%0d", $time,
                 out_data_o.distance, out_data_o.degenerate);
        errors++;
      end else begin
        want = dist_q.pop_front();
        if (out_data_o.distance !== want.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time, want.distance,
                   out_data_o.distance);
          errors++;
        end
        if (out_data_o.degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %0d actual %0d", $time, want.degenerate,
                   out_data_o.degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    #(20 * 600000);
    $display("tb_point_to_line_distance_3d: done, errors");
    $finish;
  end

  initial begin
    row_t rows [16];
    logic signed [COORD_W-1:0] o [3];
    logic signed [COORD_W-1:0] d [3];
    line_set_e cur;
    pt_out_t none;
    none = '0;
    rows[0]  = '{LINE_RESET, pt(0, 3 * ONE, 4 * ONE), 1, '{34'd327680, 1'b0}};
    rows[1]  = '{LINE_RESET, pt(ONE * 7 + ONE / 2, 0, 0), 1, '{34'd0, 1'b0}};
    rows[2]  = '{LINE_RESET, pt(-1, 0, 0), 1, '{34'd0, 1'b0}};
    rows[3]  = '{LINE_RESET, pt(0, -ONE, 0), 1, '{34'd65536, 1'b0}};
    rows[4]  = '{LINE_RESET, pt(1, 1, 0), 1, '{34'd1, 1'b0}};
    rows[5]  = '{LINE_RESET, pt(CMAX, CMAX, CMAX), 0, none};
    rows[6]  = '{LINE_RESET, pt(CMIN, CMIN, CMIN), 0, none};
    rows[7]  = '{LINE_RESET, pt(CMIN, CMAX, 0), 0, none};
    rows[8]  = '{LINE_ZERO_DIR, pt(3 * ONE, 4 * ONE, 0), 1, '{34'd327680, 1'b1}};
    rows[9]  = '{LINE_ZERO_DIR, pt(0, 0, -2 * ONE), 1, '{34'd131072, 1'b1}};
    rows[10] = '{LINE_ZERO_DIR, pt(0, 0, 0), 1, '{34'd0, 1'b1}};
    rows[11] = '{LINE_ZERO_DIR, pt(CMIN, CMIN, CMIN), 0, none};
    rows[12] = '{LINE_ZERO_DIR, pt(CMAX, 0, CMIN), 0, none};
    rows[13] = '{LINE_FAR, pt(CMAX, CMAX, CMAX), 1, '{34'd0, 1'b0}};
    rows[14] = '{LINE_FAR, pt(CMIN, CMIN, CMIN), 0, none};
    rows[15] = '{LINE_FAR, pt(CMIN, CMAX, -1), 0, none};

    line_org = '{0, 0, 0};
    line_dir = '{ONE, 0, 0};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    cur = LINE_RESET;
    foreach (rows[i]) begin
      if (rows[i].line != cur) begin
        cur = rows[i].line;
        if (cur == LINE_ZERO_DIR) begin
          o = '{0, 0, 0}; d = '{0, 0, 0};
        end else begin
          o = '{CMAX, CMAX, CMAX}; d = '{CMIN, CMIN, CMIN};
        end
        set_line(o, d);
      end
      send(rows[i].p, rows[i].typed, rows[i].e);
    end

    for (int n = 0; n < 1300; n++) begin
      if (n % 100 == 0) begin
        case (n / 100 % 6)
          0: begin o = '{CMIN, CMAX, 0}; d = '{CMAX, CMAX, CMAX}; end
          1: begin o = '{0, 0, 0}; d = '{0, 0, 0}; end
          2: begin o = '{0, 0, 0}; d = '{0, 0, ONE}; end
          default: begin
            foreach (o[k]) o[k] = rand_coord();
            foreach (d[k]) d[k] = ($urandom_range(3) == 0) ? 0 : rand_coord();
          end
        endcase
        set_line(o, d);
      end
      if (n < 430) begin
        tx_idle = 31; rx_idle = 73;
      end else if (n < 860) begin
        tx_idle = 73; rx_idle = 31;
      end else begin
        tx_idle = 0; rx_idle = 0;
      end
      if (n == 250) begin
        in_valid_i = 1'b0;
        wait (dist_q.size() == 0);
        @(negedge clk_i);
      end
      send(pt(rand_coord(), rand_coord(), rand_coord()), 0, none);
    end

    in_valid_i = 1'b0;
    wait (dist_q.size() == 0);
    repeat (120) @(posedge clk_i);
    if (errors == 0 && dist_q.size() == 0)
      $display("tb_point_to_line_distance_3d: done, clean");
    else
      $display("tb_point_to_line_distance_3d: done, errors");
    $finish;
  end

endmodule

### sim.f
src/ptld_pkg.sv
src/point_to_line_distance_3d.sv
sim/tb_point_to_line_distance_3d.sv
